@@ rtl/cdq_pkg.sv @@
// shared types and codes for the circular deque
package cdq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    // operation codes of an input transaction
    localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    // status codes of a result transaction
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // register byte address of capacity
    localparam logic [1:0] REG_CAPACITY = 2'd0;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_value;
        logic [COUNT_W-1:0]       entry_count;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_POP_BACK,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

@@ rtl/cdq_cell.sv @@
// one deque cell: an entry with its occupied bit, shifting to either neighbor
module cdq_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cdq_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_left_occ,
    input  logic [cdq_pkg::DATA_W-1:0] i_left_data,
    input  logic                      i_right_occ,
    input  logic [cdq_pkg::DATA_W-1:0] i_right_data,
    output logic                      o_occ,
    output logic [cdq_pkg::DATA_W-1:0] o_data,
    output logic [cdq_pkg::DATA_W-1:0] o_tail_data
);
    import cdq_pkg::*;

    logic              r_occ;
    logic              n_occ;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_is_tail;

    // last occupied cell of the row
    assign w_is_tail = r_occ && !i_right_occ;

    always_comb begin
        n_occ  = r_occ;
        n_data = r_data;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_PUSH_FRONT: begin
                n_occ  = i_left_occ;
                n_data = i_left_data;
            end
            CELL_PUSH_BACK: begin
                if (!r_occ && i_left_occ) begin
                    n_occ  = 1'b1;
                    n_data = i_ctl.value;
                end
            end
            CELL_POP_FRONT: begin
                n_occ  = i_right_occ;
                n_data = i_right_data;
            end
            CELL_POP_BACK: begin
                if (w_is_tail) begin
                    n_occ = 1'b0;
                end
            end
            CELL_CLEAR: begin
                n_occ = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_occ       = r_occ;
    assign o_data      = r_data;
    assign o_tail_data = w_is_tail ? r_data : '0;

endmodule

@@ rtl/circular_deque.sv @@
// top level of the circular deque: handshake, capacity register and the cell row
//
// A double-ended queue of signed 32-bit values. Each input transaction asks
// for one operation (push back, push front, pop front, pop back) and gives
// exactly one result transaction with a status, the popped value (zero unless
// a pop succeeded) and the number of entries held afterward. The entries sit
// in a row of cells with the front at cell 0; a push or pop at the front
// shifts the whole row by one cell at once, while operations at the
// back touch only the cell at the end of the occupied run (the first free
// cell for a push, the last occupied cell for a pop). One transaction is
// accepted per cycle while the input is not stalled, and its result
// appears in the output register on the next cycle; the output register lets
// a new transaction enter while the previous result is taken. The input
// stalls only while a result waits under output stall. Writing the capacity
// register (clamped to 1..min(DEPTH,31); zero acts as one) empties the deque.
module circular_deque #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cdq_pkg::t_in_item     i_in_item,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cdq_pkg::t_out_item    o_out_item,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import cdq_pkg::*;

    // capacity is a 5-bit field, so more than 31 cells are never reachable
    localparam int unsigned    NCELL   = (DEPTH < 31) ? DEPTH : 31;
    localparam logic [COUNT_W-1:0] CAP_MAX = COUNT_W'(NCELL);

    // capacity register: raw value for readback, clamped value for use
    logic [COUNT_W-1:0] r_capacity;
    logic [COUNT_W-1:0] r_cap_act;
    logic [COUNT_W-1:0] w_wr_cap;
    logic               w_cfg_wr;

    // entry count and output register
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_out_valid;
    t_out_item          r_out_item;
    t_out_item          n_out_item;

    // cell row wiring
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_ok;
    t_cell_ctl          w_ctl;
    logic [NCELL-1:0]   w_occ;
    logic [DATA_W-1:0]  w_data      [NCELL];
    logic [DATA_W-1:0]  w_tail_data [NCELL];
    logic [DATA_W-1:0]  w_back_val;

    // register port: always ready, write completes in the access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == REG_CAPACITY);
    assign w_wr_cap = pwdata[COUNT_W-1:0];
    assign prdata   = (paddr == REG_CAPACITY) ? {{(32-COUNT_W){1'b0}}, r_capacity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_MAX;
            r_cap_act  <= CAP_MAX;
        end else if (w_cfg_wr) begin
            r_capacity <= w_wr_cap;
            if (w_wr_cap == '0) begin
                r_cap_act <= COUNT_W'(1);
            end else if (w_wr_cap > CAP_MAX) begin
                r_cap_act <= CAP_MAX;
            end else begin
                r_cap_act <= w_wr_cap;
            end
        end
    end

    // handshake: stall only while a result is held back
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_full  = (r_count >= r_cap_act);
    assign w_empty = (r_count == '0);

    // a push succeeds when not full, a pop when not empty
    always_comb begin
        if (i_in_item.operation == OP_PUSH_BACK || i_in_item.operation == OP_PUSH_FRONT) begin
            w_ok = !w_full;
        end else begin
            w_ok = !w_empty;
        end
    end

    // command broadcast to every cell
    always_comb begin
        w_ctl.value = i_in_item.value;
        w_ctl.op    = CELL_HOLD;
        if (w_cfg_wr) begin
            w_ctl.op = CELL_CLEAR;
        end else if (w_accept && w_ok) begin
            unique case (i_in_item.operation)
                OP_PUSH_BACK:  w_ctl.op = CELL_PUSH_BACK;
                OP_PUSH_FRONT: w_ctl.op = CELL_PUSH_FRONT;
                OP_POP_FRONT:  w_ctl.op = CELL_POP_FRONT;
                OP_POP_BACK:   w_ctl.op = CELL_POP_BACK;
                default:       w_ctl.op = CELL_HOLD;
            endcase
        end
    end

    // row of cells; cell 0 sees the pushed value as its left neighbor
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic              w_l_occ;
        logic [DATA_W-1:0] w_l_data;
        logic              w_r_occ;
        logic [DATA_W-1:0] w_r_data;

        if (g == 0) begin : g_first
            assign w_l_occ  = 1'b1;
            assign w_l_data = i_in_item.value;
        end else begin : g_mid_l
            assign w_l_occ  = w_occ[g-1];
            assign w_l_data = w_data[g-1];
        end

        if (g == NCELL - 1) begin : g_last
            assign w_r_occ  = 1'b0;
            assign w_r_data = '0;
        end else begin : g_mid_r
            assign w_r_occ  = w_occ[g+1];
            assign w_r_data = w_data[g+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_left_occ   (w_l_occ),
            .i_left_data  (w_l_data),
            .i_right_occ  (w_r_occ),
            .i_right_data (w_r_data),
            .o_occ        (w_occ[g]),
            .o_data       (w_data[g]),
            .o_tail_data  (w_tail_data[g])
        );
    end

    // only the last occupied cell drives a nonzero tail word
    always_comb begin
        w_back_val = '0;
        for (int i = 0; i < NCELL; i++) begin
            w_back_val = w_back_val | w_tail_data[i];
        end
    end

    // result of the transaction being accepted
    always_comb begin
        n_count                 = r_count;
        n_out_item.status       = ST_DONE;
        n_out_item.popped_value = '0;
        unique case (i_in_item.operation)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (w_ok) begin
                    n_count = r_count + COUNT_W'(1);
                end else begin
                    n_out_item.status = ST_OVERFLOW;
                end
            end
            OP_POP_FRONT: begin
                if (w_ok) begin
                    n_count                 = r_count - COUNT_W'(1);
                    n_out_item.popped_value = w_data[0];
                end else begin
                    n_out_item.status = ST_UNDERFLOW;
                end
            end
            OP_POP_BACK: begin
                if (w_ok) begin
                    n_count                 = r_count - COUNT_W'(1);
                    n_out_item.popped_value = w_back_val;
                end else begin
                    n_out_item.status = ST_UNDERFLOW;
                end
            end
            default: begin
            end
        endcase
        n_out_item.entry_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_count <= '0;
            end else if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

endmodule
